[rtl/core/rwbc_pkg.sv]
// Shared types and codes for the register write burst combiner.
package rwbc_pkg;

    // Register-list entry codes
    localparam logic [1:0] CMD_W8    = 2'd0;
    localparam logic [1:0] CMD_W16   = 2'd1;
    localparam logic [1:0] CMD_DELAY = 2'd2;
    localparam logic [1:0] CMD_END   = 2'd3;

    // Result kinds
    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_DELAY = 1'b1;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] reg_addr;
        logic [15:0] value;
    } cmd_item_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [15:0] delay_ms;
        logic        message_end;
        logic        last;
    } msg_item_t;

endpackage

[rtl/core/rwbc_out_stage.sv]
// Output register stage: holds one result item until the receiver takes it.
module rwbc_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  rwbc_pkg::msg_item_t load_item,
    output logic                free,
    output logic                msg_valid,
    input  logic                msg_stall,
    output rwbc_pkg::msg_item_t msg_data
);

    logic                valid_reg;
    logic                valid_next;
    rwbc_pkg::msg_item_t item_reg;

    // slot can take a new item when empty or when the held one leaves now
    assign free = !valid_reg || !msg_stall;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (msg_stall)
        begin
            valid_next = valid_reg;
        end
        else
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= load_item;
        end
    end

    assign msg_valid = valid_reg;
    assign msg_data  = item_reg;

endmodule

[rtl/core/register_write_burst_combiner.sv]
// Top level of the register write burst combiner: sequencer and burst buffer.
//
// Usage: register-list entries enter on the cmd channel (cmd_valid/cmd_stall,
// payload cmd_data); results leave on the msg channel (msg_valid/msg_stall,
// payload msg_data), one byte of a bus message or one delay request per item.
// Writes to consecutive addresses collect in a BUF_BYTES-deep buffer memory;
// a flush sends address high, address low, then the buffered bytes.
// One entry is taken at a time: cmd_stall is high from the cycle after
// acceptance until the entry's work is done.
// During a flush the buffered bytes leave one byte per cycle out of the buffer
// memory read port, unless the receiver stalls with a result held. Results
// appear in the cycle after they are produced, through an output register.
// When the receiver stalls, the held result stays and the sequencer waits before its next result.
// Reset empties the burst (fill count zero); buffer contents are not cleared
// and need no clearing, since only written entries are ever read.
module register_write_burst_combiner #(
    parameter int BUF_BYTES = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  rwbc_pkg::cmd_item_t cmd_data,
    output logic                msg_valid,
    input  logic                msg_stall,
    output rwbc_pkg::msg_item_t msg_data
);

    localparam int CW = $clog2(BUF_BYTES);
    localparam logic [CW:0] BUF_LIMIT = (CW+1)'(BUF_BYTES);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_CHECK   = 4'd1;
    localparam logic [3:0] ST_ADDR_HI = 4'd2;
    localparam logic [3:0] ST_ADDR_LO = 4'd3;
    localparam logic [3:0] ST_DATA    = 4'd4;
    localparam logic [3:0] ST_STORE_A = 4'd5;
    localparam logic [3:0] ST_STORE_B = 4'd6;
    localparam logic [3:0] ST_POST    = 4'd7;
    localparam logic [3:0] ST_DELAY   = 4'd8;

    logic [3:0]          state_reg,  state_next;
    rwbc_pkg::cmd_item_t item_reg,   item_next;
    logic [CW-1:0]       fill_reg,   fill_next;
    logic [15:0]         start_reg,  start_next;
    logic                pre_reg,    pre_next;
    logic [CW-1:0]       rd_idx_reg, rd_idx_next;
    logic [7:0]          rd_data_reg;

    logic [7:0]          burst_mem [BUF_BYTES];

    logic                wr_en;
    logic [CW-1:0]       wr_idx;
    logic [7:0]          wr_byte;
    logic                rd_en;
    logic [CW-1:0]       rd_addr;

    logic                emit;
    rwbc_pkg::msg_item_t emit_item;
    logic                emit_ok;

    logic                is_w16;
    logic                is_delay;
    logic                is_end;
    logic                fill_zero;
    logic                mismatch;
    logic [CW:0]         step;
    logic                early_post;
    logic                post_need;
    logic                data_end;
    logic                last_pre;

    assign is_w16    = item_reg.command == rwbc_pkg::CMD_W16;
    assign is_delay  = item_reg.command == rwbc_pkg::CMD_DELAY;
    assign is_end    = item_reg.command == rwbc_pkg::CMD_END;
    assign fill_zero = fill_reg == '0;
    assign mismatch  = (start_reg + 16'(fill_reg)) != item_reg.reg_addr;
    assign step      = is_w16 ? (CW+1)'(2) : (CW+1)'(1);
    // set when a write that follows a flush fills the buffer far enough to flush again
    assign early_post = (step + (CW+1)'(2)) >= BUF_LIMIT;
    assign post_need  = ({1'b0, fill_reg} + (CW+1)'(2)) >= BUF_LIMIT;
    assign data_end   = ({1'b0, rd_idx_reg} + (CW+1)'(1)) == {1'b0, fill_reg};
    assign last_pre   = is_end || (!is_delay && !early_post);

    assign cmd_stall = state_reg != ST_IDLE;

    always_comb
    begin
        state_next  = state_reg;
        item_next   = item_reg;
        fill_next   = fill_reg;
        start_next  = start_reg;
        pre_next    = pre_reg;
        rd_idx_next = rd_idx_reg;
        wr_en       = 1'b0;
        wr_idx      = fill_reg;
        wr_byte     = item_reg.value[7:0];
        rd_en       = 1'b0;
        rd_addr     = rd_idx_reg;
        emit        = 1'b0;
        emit_item   = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    item_next  = cmd_data;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (!fill_zero && (is_delay || is_end || mismatch))
                begin
                    pre_next   = 1'b1;
                    state_next = ST_ADDR_HI;
                end
                else if (is_delay)
                begin
                    state_next = ST_DELAY;
                end
                else if (is_end)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_STORE_A;
                end
            end
            ST_ADDR_HI:
            begin
                if (emit_ok)
                begin
                    emit                = 1'b1;
                    emit_item.kind      = rwbc_pkg::KIND_BYTE;
                    emit_item.data_byte = start_reg[15:8];
                    // fetch the first buffered byte early
                    rd_en       = 1'b1;
                    rd_addr     = '0;
                    rd_idx_next = '0;
                    state_next  = ST_ADDR_LO;
                end
            end
            ST_ADDR_LO:
            begin
                if (emit_ok)
                begin
                    emit                = 1'b1;
                    emit_item.kind      = rwbc_pkg::KIND_BYTE;
                    emit_item.data_byte = start_reg[7:0];
                    state_next          = ST_DATA;
                end
            end
            ST_DATA:
            begin
                if (emit_ok)
                begin
                    emit                  = 1'b1;
                    emit_item.kind        = rwbc_pkg::KIND_BYTE;
                    emit_item.data_byte   = rd_data_reg;
                    emit_item.message_end = data_end;
                    emit_item.last        = data_end && (pre_reg ? last_pre : 1'b1);
                    if (data_end)
                    begin
                        fill_next = '0;
                        pre_next  = 1'b0;
                        if (!pre_reg || is_end)
                        begin
                            state_next = ST_IDLE;
                        end
                        else if (is_delay)
                        begin
                            state_next = ST_DELAY;
                        end
                        else
                        begin
                            state_next = ST_STORE_A;
                        end
                    end
                    else
                    begin
                        rd_en       = 1'b1;
                        rd_addr     = rd_idx_reg + CW'(1);
                        rd_idx_next = rd_idx_reg + CW'(1);
                    end
                end
            end
            ST_STORE_A:
            begin
                wr_en   = 1'b1;
                wr_byte = is_w16 ? item_reg.value[15:8] : item_reg.value[7:0];
                if (fill_zero)
                begin
                    start_next = item_reg.reg_addr;
                end
                fill_next  = fill_reg + CW'(1);
                state_next = is_w16 ? ST_STORE_B : ST_POST;
            end
            ST_STORE_B:
            begin
                wr_en      = 1'b1;
                wr_byte    = item_reg.value[7:0];
                fill_next  = fill_reg + CW'(1);
                state_next = ST_POST;
            end
            ST_POST:
            begin
                if (post_need)
                begin
                    pre_next   = 1'b0;
                    state_next = ST_ADDR_HI;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DELAY:
            begin
                if (emit_ok)
                begin
                    emit               = 1'b1;
                    emit_item.kind     = rwbc_pkg::KIND_DELAY;
                    emit_item.delay_ms = item_reg.value;
                    emit_item.last     = 1'b1;
                    state_next         = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            start_reg <= '0;
            pre_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            start_reg <= start_next;
            pre_reg   <= pre_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        rd_idx_reg <= rd_idx_next;
    end

    // burst buffer: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            burst_mem[wr_idx] <= wr_byte;
        end
        if (rd_en)
        begin
            rd_data_reg <= burst_mem[rd_addr];
        end
    end

    rwbc_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (emit),
        .load_item (emit_item),
        .free      (emit_ok),
        .msg_valid (msg_valid),
        .msg_stall (msg_stall),
        .msg_data  (msg_data)
    );

endmodule

[bench/register_write_burst_combiner_tb.sv]
// Self-checking testbench for the register write burst combiner.
module register_write_burst_combiner_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BUF_BYTES   = 32;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 250;

    // Predicts the bus message bytes and delay requests each entry causes, then checks them.
    class burst_scoreboard;
        logic [7:0]          burst_mem [BUF_BYTES];
        logic [5:0]          fill;
        logic [15:0]         start_addr;
        rwbc_pkg::msg_item_t step_q[$];
        rwbc_pkg::msg_item_t expected_q[$];
        int unsigned         items_seen;
        int unsigned         results_seen;
        int unsigned         messages_seen;
        int unsigned         delays_seen;
        int unsigned         mismatches;

        function new();
            fill          = '0;
            start_addr    = '0;
            items_seen    = 0;
            results_seen  = 0;
            messages_seen = 0;
            delays_seen   = 0;
            mismatches    = 0;
        endfunction

        function void push_result(logic kind, logic [7:0] b, logic [15:0] ms, logic mend);
            rwbc_pkg::msg_item_t m;
            m.kind        = kind;
            m.data_byte   = b;
            m.delay_ms    = ms;
            m.message_end = mend;
            m.last        = 1'b0;
            step_q.push_back(m);
        endfunction

        function void store_byte(int idx, logic [7:0] b);
            if (idx < BUF_BYTES)
                burst_mem[idx] = b;
        endfunction

        function void flush_burst();
            if (fill == 0)
                return;
            push_result(rwbc_pkg::KIND_BYTE, start_addr[15:8], 16'h0000, 1'b0);
            push_result(rwbc_pkg::KIND_BYTE, start_addr[7:0], 16'h0000, 1'b0);
            for (int i = 0; i < int'(fill) && i < BUF_BYTES; i++)
                push_result(rwbc_pkg::KIND_BYTE, burst_mem[i], 16'h0000,
                            (i + 1 == int'(fill)));
            fill = '0;
        endfunction

        function void note_input(rwbc_pkg::cmd_item_t it);
            logic [15:0] next_addr;
            step_q.delete();
            items_seen++;
            if (it.command == rwbc_pkg::CMD_DELAY)
            begin
                flush_burst();
                push_result(rwbc_pkg::KIND_DELAY, 8'h00, it.value, 1'b0);
            end
            else if (it.command == rwbc_pkg::CMD_END)
            begin
                flush_burst();
            end
            else
            begin
                next_addr = start_addr + 16'(fill);
                // close the running burst before a write that does not follow on
                if (fill != 0 && next_addr != it.reg_addr)
                    flush_burst();
                if (it.command == rwbc_pkg::CMD_W8)
                begin
                    store_byte(int'(fill), it.value[7:0]);
                end
                else
                begin
                    store_byte(int'(fill), it.value[15:8]);
                    store_byte(int'(fill) + 1, it.value[7:0]);
                end
                if (fill == 0)
                    start_addr = it.reg_addr;
                fill = fill + ((it.command == rwbc_pkg::CMD_W8) ? 6'd1 : 6'd2);
                if (int'(fill) + 2 >= BUF_BYTES)
                    flush_burst();
            end
            foreach (step_q[i])
            begin
                rwbc_pkg::msg_item_t m;
                m      = step_q[i];
                m.last = (i == step_q.size() - 1);
                expected_q.push_back(m);
            end
        endfunction

        function void check_result(rwbc_pkg::msg_item_t got);
            rwbc_pkg::msg_item_t want;
            results_seen++;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result kind=%0d byte=%02h delay=%0d end=%0d last=%0d",
                             $realtime, got.kind, got.data_byte, got.delay_ms,
                             got.message_end, got.last);
                return;
            end
            want = expected_q.pop_front();
            if (want.kind == rwbc_pkg::KIND_DELAY)
                delays_seen++;
            else if (want.message_end)
                messages_seen++;
            if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
                got.delay_ms !== want.delay_ms || got.message_end !== want.message_end ||
                got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: result mismatch", $realtime);
                    $display("  expected kind=%0d byte=%02h delay=%0d end=%0d last=%0d",
                             want.kind, want.data_byte, want.delay_ms,
                             want.message_end, want.last);
                    $display("  actual   kind=%0d byte=%02h delay=%0d end=%0d last=%0d",
                             got.kind, got.data_byte, got.delay_ms,
                             got.message_end, got.last);
                end
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cmd_valid = 1'b0;
    logic                cmd_stall;
    rwbc_pkg::cmd_item_t cmd_data = '0;
    logic                msg_valid;
    logic                msg_stall = 1'b0;
    rwbc_pkg::msg_item_t msg_data;

    burst_scoreboard sb;
    int send_idle_pct = 11;
    int recv_idle_pct = 60;
    int hold_left     = 0;
    bit hold_req      = 1'b0;
    bit hold_taken    = 1'b0;
    int cycle_count   = 0;

    register_write_burst_combiner #(
        .BUF_BYTES (BUF_BYTES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_data  (cmd_data),
        .msg_valid (msg_valid),
        .msg_stall (msg_stall),
        .msg_data  (msg_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: long hold-off when requested, otherwise random stalls
    always @(negedge clk)
    begin
        if (hold_req && !hold_taken)
        begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            msg_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
        begin
            msg_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && msg_valid && !msg_stall)
            sb.check_result(msg_data);
    end

    function automatic rwbc_pkg::cmd_item_t make_item(logic [1:0] c, logic [15:0] a,
                                                       logic [15:0] v);
        rwbc_pkg::cmd_item_t it;
        it.command  = c;
        it.reg_addr = a;
        it.value    = v;
        return it;
    endfunction

    task automatic offer(rwbc_pkg::cmd_item_t it);
        int n;
        if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            n = $urandom_range(1, 6);
            @(negedge clk);
            cmd_valid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
        @(negedge clk);
        cmd_valid <= 1'b1;
        cmd_data  <= it;
        do
            @(posedge clk);
        while (cmd_stall);
        sb.note_input(it);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [15:0] pick_start();
        case ($urandom_range(0, 2))
            0:       return 16'($urandom);
            1:       return 16'hFFF0 + 16'($urandom_range(0, 15));
            default: return 16'($urandom_range(0, 63));
        endcase
    endfunction

    // mostly runs of consecutive writes with random data, the rest loose entries
    task automatic run_random(int count);
        int          done;
        int          len;
        logic [1:0]  c;
        logic [15:0] addr;
        done = 0;
        while (done < count)
        begin
            if ($urandom_range(0, 99) < 70)
            begin
                addr = pick_start();
                len  = $urandom_range(1, 20);
                for (int j = 0; j < len && done < count; j++)
                begin
                    c = $urandom_range(0, 1) ? rwbc_pkg::CMD_W16 : rwbc_pkg::CMD_W8;
                    offer(make_item(c, addr, 16'($urandom)));
                    addr = addr + ((c == rwbc_pkg::CMD_W16) ? 16'd2 : 16'd1);
                    done++;
                end
                case ($urandom_range(0, 3))
                    0:
                    begin
                        offer(make_item(rwbc_pkg::CMD_DELAY, 16'($urandom), 16'($urandom)));
                        done++;
                    end
                    1:
                    begin
                        offer(make_item(rwbc_pkg::CMD_END, 16'($urandom), 16'($urandom)));
                        done++;
                    end
                    default: ;
                endcase
            end
            else
            begin
                c = 2'($urandom_range(0, 3));
                offer(make_item(c, 16'($urandom), 16'($urandom)));
                done++;
            end
        end
    endtask

    initial
    begin
        sb = new();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // sender idles lightly, receiver heavily
        send_idle_pct = 11;
        recv_idle_pct = 60;
        offer(make_item(rwbc_pkg::CMD_W8, 16'h0000, 16'hFF00));
        offer(make_item(rwbc_pkg::CMD_W8, 16'h0001, 16'h00FF));
        offer(make_item(rwbc_pkg::CMD_W16, 16'h0002, 16'hFFFF));
        offer(make_item(rwbc_pkg::CMD_W8, 16'h1234, 16'h0055));
        offer(make_item(rwbc_pkg::CMD_DELAY, 16'hFFFF, 16'h0000));
        offer(make_item(rwbc_pkg::CMD_DELAY, 16'h0000, 16'hFFFF));
        offer(make_item(rwbc_pkg::CMD_END, 16'hABCD, 16'h1234));
        offer(make_item(rwbc_pkg::CMD_W16, 16'hFFFF, 16'hA55A));
        // wraps past the top of the address space
        offer(make_item(rwbc_pkg::CMD_W8, 16'h0001, 16'h0080));
        offer(make_item(rwbc_pkg::CMD_END, 16'hFFFF, 16'hFFFF));
        // fill the buffer until it flushes on its own
        for (int i = 0; i < 15; i++)
            offer(make_item(rwbc_pkg::CMD_W16, 16'h8000 + 16'(2 * i), 16'(i * 16'h1111)));
        run_random(12);
        hold_req = 1'b1;
        run_random(23);
        wait_drained();

        // sender idles heavily, receiver lightly
        send_idle_pct = 60;
        recv_idle_pct = 11;
        run_random(35);
        wait_drained();

        // full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(17);
        wait_drained();
        run_random(18);
        offer(make_item(rwbc_pkg::CMD_END, 16'h0000, 16'h0000));
        wait_drained();
        repeat (10) @(posedge clk);

        $display("covered %0d entries, %0d results: %0d bus messages, %0d delay requests",
                 sb.items_seen, sb.results_seen, sb.messages_seen, sb.delays_seen);
        $display("%0d mismatches, %0d results still outstanding",
                 sb.mismatches, sb.expected_q.size());
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
